[hw/rtl/trs_pkg.sv]
// trs_pkg: shared widths, types and helpers of the temperature run statistics block.
// Used by every module under hw/rtl; depends on nothing.

package trs_pkg;

  // run length limit: counters saturate here
  localparam int MAX_READINGS = 1024;

  // field widths fixed by the stream format
  localparam int READING_W = 16;
  localparam int VALUE_W   = READING_W - 1;
  localparam int THRESH_W  = 15;
  localparam int OUT_CNT_W = 11;
  localparam int OUT_IDX_W = 10;
  localparam int M_DATA_W  = 112;
  localparam int M_USER_W  = 2;

  // widths that follow from the run length limit
  localparam int CNT_W  = $clog2(MAX_READINGS + 1);
  localparam int POS_W  = $clog2(MAX_READINGS);
  localparam int SUM_W  = VALUE_W + $clog2(MAX_READINGS);
  localparam int STEP_W = $clog2(SUM_W);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WARNING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN = 2'd2;

  // threshold reset values
  localparam logic [THRESH_W-1:0] WARNING_RESET  = 15'd480;
  localparam logic [THRESH_W-1:0] CRITICAL_RESET = 15'd720;
  localparam logic [THRESH_W-1:0] SHUTDOWN_RESET = 15'd960;

  // queue depth between classifier and accumulator
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    BAND_NORMAL   = 2'd0,
    BAND_WARNING  = 2'd1,
    BAND_CRITICAL = 2'd2,
    BAND_SHUTDOWN = 2'd3
  } band_t;

  // one classified sample
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               err;
    band_t              band;
    logic               crit;
    logic               last;
  } trs_entry_t;

  // run statistics handed from accumulator to divider
  typedef struct packed {
    logic [VALUE_W-1:0]          low;
    logic [VALUE_W-1:0]          high;
    logic [SUM_W-1:0]            sum;
    logic [CNT_W-1:0]            count;
    logic [CNT_W-1:0]            err;
    logic [3:0][CNT_W-1:0]       bands;
    logic [POS_W-1:0]            crit_pos;
    logic                        crit_flag;
  } trs_stats_t;

  typedef enum logic [1:0] {
    DIV_IDLE = 2'd0,
    DIV_RUN  = 2'd1,
    DIV_DONE = 2'd2
  } trs_div_state_t;

  // saturating increment at the run length limit
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v < CNT_W'(MAX_READINGS)) ? v + CNT_W'(1) : CNT_W'(MAX_READINGS);
    return r;
  endfunction

endpackage

[hw/rtl/trs_queue.sv]
// trs_queue: short fifo of classified samples between classifier and accumulator.
// Depends on trs_pkg for the entry type and depth.

module trs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  trs_pkg::trs_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               entry_valid,
  output trs_pkg::trs_entry_t entry
);
  import trs_pkg::*;

  trs_entry_t          slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_PTR_W:0]    fill;

  // status
  assign full        = (fill == (Q_PTR_W + 1)'(Q_DEPTH));
  assign entry_valid = (fill != '0);
  assign entry       = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + (Q_PTR_W + 1)'(1);
        2'b01:   fill <= fill - (Q_PTR_W + 1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hw/rtl/trs_front.sv]
// trs_front: threshold registers and sample classifier feeding the queue.
// Depends on trs_pkg for widths, register indexes and the entry type.

module trs_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [trs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trs_pkg::THRESH_W-1:0]      cfg_data,
  input  logic                              in_valid,
  input  logic [trs_pkg::READING_W-1:0]     in_reading,
  input  logic                              in_last,
  input  logic                              q_full,
  output logic                              in_ready,
  output logic                              push,
  output trs_pkg::trs_entry_t               push_entry
);
  import trs_pkg::*;

  logic [THRESH_W-1:0] warning_threshold;
  logic [THRESH_W-1:0] critical_threshold;
  logic [THRESH_W-1:0] shutdown_threshold;
  logic [VALUE_W-1:0]  value;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      warning_threshold  <= WARNING_RESET;
      critical_threshold <= CRITICAL_RESET;
      shutdown_threshold <= SHUTDOWN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WARNING:  warning_threshold  <= cfg_data;
        REG_CRITICAL: critical_threshold <= cfg_data;
        REG_SHUTDOWN: shutdown_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // accept while the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign value    = in_reading[VALUE_W-1:0];

  // classify the sample into error, band and critical mark
  always_comb begin
    push_entry.value = value;
    push_entry.err   = in_reading[READING_W-1];
    push_entry.last  = in_last;
    push_entry.crit  = (value >= critical_threshold);
    if (value < warning_threshold) begin
      push_entry.band = BAND_NORMAL;
    end else if (value < critical_threshold) begin
      push_entry.band = BAND_WARNING;
    end else if (value < shutdown_threshold) begin
      push_entry.band = BAND_CRITICAL;
    end else begin
      push_entry.band = BAND_SHUTDOWN;
    end
  end

endmodule

[hw/rtl/trs_accum.sv]
// trs_accum: run accumulator; folds queued samples into min, max, sum and counts.
// Depends on trs_pkg for the entry and statistics types and sat_inc.

module trs_accum (
  input  logic                clk,
  input  logic                rst,
  input  logic                entry_valid,
  input  trs_pkg::trs_entry_t entry,
  input  logic                div_idle,
  output logic                pop,
  output logic                start,
  output trs_pkg::trs_stats_t stats
);
  import trs_pkg::*;

  trs_stats_t       acc;
  trs_stats_t       acc_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;

  // the closing sample waits until the divider is free
  assign pop   = entry_valid && (!entry.last || div_idle);
  assign start = pop && entry.last;
  assign stats = acc_next;

  // update of the run state by one sample
  always_comb begin
    acc_next = acc;
    if (entry.err) begin
      acc_next.err = sat_inc(acc.err);
    end else begin
      if (acc.count == '0) begin
        acc_next.low  = entry.value;
        acc_next.high = entry.value;
      end else begin
        if (entry.value < acc.low) begin
          acc_next.low = entry.value;
        end
        if (entry.value > acc.high) begin
          acc_next.high = entry.value;
        end
      end
      if (acc.count < CNT_W'(MAX_READINGS)) begin
        acc_next.sum   = acc.sum + SUM_W'(entry.value);
        acc_next.count = acc.count + CNT_W'(1);
      end
      acc_next.bands[entry.band] = sat_inc(acc.bands[entry.band]);
      if (!acc.crit_flag && entry.crit) begin
        acc_next.crit_flag = 1'b1;
        acc_next.crit_pos  = pos;
      end
    end
  end

  // sample position stops one short of the limit
  always_comb begin
    pos_next = pos;
    if (pos < POS_W'(MAX_READINGS - 1)) begin
      pos_next = pos + POS_W'(1);
    end
  end

  // run state, cleared after the closing sample
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      pos <= '0;
    end else if (pop) begin
      if (entry.last) begin
        acc <= '0;
        pos <= '0;
      end else begin
        acc <= acc_next;
        pos <= pos_next;
      end
    end
  end

endmodule

[hw/rtl/trs_div.sv]
// trs_div: bit-serial mean divider and result register of the run statistics.
// Depends on trs_pkg for the statistics type, divider states and widths.

module trs_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  trs_pkg::trs_stats_t              start_stats,
  output logic                             div_idle,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [trs_pkg::M_DATA_W-1:0]     out_data,
  output logic [trs_pkg::M_USER_W-1:0]     out_user
);
  import trs_pkg::*;

  trs_div_state_t    state;
  trs_div_state_t    state_next;
  trs_stats_t        stats;
  logic [CNT_W-1:0]  rem;
  logic [SUM_W-1:0]  quo;
  logic [STEP_W-1:0] step;
  logic [CNT_W:0]    rem_shift;
  logic              fits;
  logic              none;
  logic [VALUE_W-1:0] mean;

  assign none      = (stats.count == '0);
  assign rem_shift = {rem, quo[SUM_W-1]};
  assign fits      = (rem_shift >= {1'b0, stats.count});
  assign mean      = quo[VALUE_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: begin
        if (start) begin
          state_next = (start_stats.count == '0) ? DIV_DONE : DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (step == STEP_W'(SUM_W - 1)) begin
          state_next = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (out_ready) begin
          state_next = DIV_IDLE;
        end
      end
      default: state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    case (state)
      DIV_IDLE: begin
        if (start) begin
          stats <= start_stats;
          rem   <= '0;
          quo   <= (start_stats.count == '0) ? '0 : start_stats.sum;
          step  <= '0;
        end
      end
      DIV_RUN: begin
        rem  <= fits ? CNT_W'(rem_shift - {1'b0, stats.count}) : CNT_W'(rem_shift);
        quo  <= {quo[SUM_W-2:0], fits};
        step <= step + STEP_W'(1);
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    div_idle  = (state == DIV_IDLE);
    out_valid = (state == DIV_DONE);
    out_data  = {
      2'b00,
      stats.crit_flag ? OUT_IDX_W'(stats.crit_pos) : OUT_IDX_W'(0),
      OUT_CNT_W'(stats.bands[BAND_SHUTDOWN]),
      OUT_CNT_W'(stats.bands[BAND_CRITICAL]),
      OUT_CNT_W'(stats.bands[BAND_WARNING]),
      OUT_CNT_W'(stats.bands[BAND_NORMAL]),
      OUT_CNT_W'(stats.err),
      none ? VALUE_W'(0) : mean,
      none ? VALUE_W'(0) : stats.high,
      none ? VALUE_W'(0) : stats.low
    };
    out_user  = {stats.crit_flag, none};
  end

endmodule

[hw/rtl/temperature_run_statistics.sv]
// Temperature run statistics over a stream of signed 1/16 degree samples, tlast closing a
// run. Samples are taken one per cycle while the four-entry queue behind the classifier has
// room; the accumulator drains that queue one sample per cycle. The closing sample starts a
// bit-serial divider for the mean that produces one quotient bit per bit of the running sum
// (a run with no valid sample goes straight to the result), and a further closing sample
// waits in the queue until the previous result has been taken. Runs without closing samples
// stream at one sample per cycle. Negative samples are counted as errors; counts saturate at
// 1024. Thresholds are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Depends on trs_pkg, trs_front, trs_queue, trs_accum and trs_div.

module temperature_run_statistics (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [trs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trs_pkg::THRESH_W-1:0]  cfg_data,
  // sample stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [trs_pkg::READING_W-1:0] s_tdata,   // reading[15:0]
  input  logic                          s_tlast,
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // lowest_reading[14:0], highest_reading[29:15], mean_reading[44:30],
  // error_count[55:45], normal_count[66:56], warning_count[77:67],
  // critical_count[88:78], shutdown_count[99:89], first_critical_index[109:100], zero fill
  output logic [trs_pkg::M_DATA_W-1:0]  m_tdata,
  // none_valid[0], critical_seen[1]
  output logic [trs_pkg::M_USER_W-1:0]  m_tuser
);
  import trs_pkg::*;

  logic       push;
  trs_entry_t push_entry;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  trs_entry_t q_entry;
  logic       start;
  trs_stats_t stats;
  logic       div_idle;

  // classifier and threshold registers
  trs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .in_reading (s_tdata),
    .in_last    (s_tlast),
    .q_full     (q_full),
    .in_ready   (s_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  // queue of classified samples
  trs_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_entry  (push_entry),
    .full        (q_full),
    .pop         (q_pop),
    .entry_valid (q_valid),
    .entry       (q_entry)
  );

  // run accumulator
  trs_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (q_valid),
    .entry       (q_entry),
    .div_idle    (div_idle),
    .pop         (q_pop),
    .start       (start),
    .stats       (stats)
  );

  // mean divider and result register
  trs_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .start_stats (stats),
    .div_idle    (div_idle),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (m_tdata),
    .out_user    (m_tuser)
  );

endmodule
